// ===== rtl/core/hgc_pkg.sv =====
package hgc_pkg;

   localparam int HGC_HEIGHT_BITS = 16;
   localparam int HGC_QUEUE_DEPTH = 2;
   localparam int HGC_CHAN_BITS = 8;
   localparam int HGC_COLOR_BITS = 24;
   localparam int HGC_CSR_ADDR_BITS = 3;
   localparam int HGC_CSR_DATA_BITS = 32;

   localparam logic HGC_OP_SCAN = 1'b0;
   localparam logic HGC_OP_COLOR = 1'b1;

   localparam logic HGC_REG_COLOR_LOW = 1'b0;
   localparam logic HGC_REG_COLOR_HIGH = 1'b1;

   localparam logic [HGC_COLOR_BITS-1:0] HGC_COLOR_LOW_RESET = 24'h000000;
   localparam logic [HGC_COLOR_BITS-1:0] HGC_COLOR_HIGH_RESET = 24'hffffff;

   typedef struct packed {
      logic full;
      logic empty;
   } hgc_q_stat_type;

endpackage

// ===== rtl/core/hgc_fifo.sv =====
module hgc_fifo
   import hgc_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = HGC_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output hgc_q_stat_type   stat
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full = (count_ff == CntBits'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/hgc_front.sv =====
module hgc_front
   import hgc_pkg::*;
#(
   parameter int HEIGHT_BITS = HGC_HEIGHT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  logic                     item_op,
   input  logic                     item_start,
   input  logic [HEIGHT_BITS-1:0]   item_height,
   input  hgc_q_stat_type           q_stat,
   output logic                     q_push,
   output logic [2*HEIGHT_BITS-1:0] q_data
);

   logic signed [HEIGHT_BITS-1:0] min_ff, min_in;
   logic signed [HEIGHT_BITS-1:0] max_ff, max_in;
   logic                          valid_ff, valid_in;
   logic signed [HEIGHT_BITS-1:0] h;
   logic signed [HEIGHT_BITS-1:0] h_clamp;
   logic [HEIGHT_BITS-1:0]        num;
   logic [HEIGHT_BITS-1:0]        span;
   logic                          accept;

   assign h = $signed(item_height);
   assign item_ready = !q_stat.full;
   assign accept = item_valid && item_ready;
   assign q_push = accept && (item_op == HGC_OP_COLOR);

   always_comb begin
      if (h < min_ff) begin
         h_clamp = min_ff;
      end else if (h > max_ff) begin
         h_clamp = max_ff;
      end else begin
         h_clamp = h;
      end
      num = HEIGHT_BITS'($unsigned(h_clamp - min_ff));
      span = HEIGHT_BITS'($unsigned(max_ff - min_ff));
   end

   assign q_data = {num, span};

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      valid_in = valid_ff;
      if (accept && (item_op == HGC_OP_SCAN)) begin
         valid_in = 1'b1;
         if (item_start || !valid_ff) begin
            min_in = h;
            max_in = h;
         end else begin
            if (h > max_ff) begin
               max_in = h;
            end
            if (h < min_ff) begin
               min_in = h;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/hgc_back.sv =====
module hgc_back
   import hgc_pkg::*;
#(
   parameter int HEIGHT_BITS = HGC_HEIGHT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hgc_q_stat_type            q_stat,
   input  logic [2*HEIGHT_BITS-1:0]  q_data,
   output logic                      q_pop,
   input  logic [HGC_COLOR_BITS-1:0] color_low,
   input  logic [HGC_COLOR_BITS-1:0] color_high,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [HGC_COLOR_BITS-1:0] out_color
);

   localparam int ProdBits = HEIGHT_BITS + HGC_CHAN_BITS;
   localparam int StepBits = $clog2(HGC_CHAN_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_PUSH
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                ch_ff, ch_in;
   logic [HEIGHT_BITS-1:0]    num_ff, num_in;
   logic [HEIGHT_BITS-1:0]    span_ff, span_in;
   logic [ProdBits-1:0]       rem_ff, rem_in;
   logic [ProdBits-1:0]       div_ff, div_in;
   logic [HGC_CHAN_BITS-1:0]  quo_ff, quo_in;
   logic [StepBits-1:0]       step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic [HGC_CHAN_BITS-1:0]  lo_ff, lo_in;
   logic [HGC_COLOR_BITS-1:0] color_ff, color_in;
   logic                      out_valid_ff, out_valid_in;
   logic [HGC_COLOR_BITS-1:0] out_color_ff, out_color_in;

   logic [HGC_CHAN_BITS-1:0]  ch_lo, ch_hi, mag, chan;
   logic                      ge;

   assign out_valid = out_valid_ff;
   assign out_color = out_color_ff;

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      num_in = num_ff;
      span_in = span_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      lo_in = lo_ff;
      color_in = color_ff;
      out_valid_in = out_valid_ff;
      out_color_in = out_color_ff;
      q_pop = 1'b0;

      ch_lo = color_low[{ch_ff, 3'b000} +: HGC_CHAN_BITS];
      ch_hi = color_high[{ch_ff, 3'b000} +: HGC_CHAN_BITS];
      mag = (ch_hi < ch_lo) ? (ch_lo - ch_hi) : (ch_hi - ch_lo);
      ge = (rem_ff >= div_ff);
      if (span_ff == '0) begin
         chan = lo_ff;
      end else if (neg_ff) begin
         chan = lo_ff - quo_ff - HGC_CHAN_BITS'(rem_ff != '0);
      end else begin
         chan = lo_ff + quo_ff;
      end

      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               num_in = q_data[2*HEIGHT_BITS-1:HEIGHT_BITS];
               span_in = q_data[HEIGHT_BITS-1:0];
               ch_in = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in = ProdBits'(mag) * ProdBits'(num_ff);
            div_in = ProdBits'(span_ff) << (HGC_CHAN_BITS - 1);
            neg_in = (ch_hi < ch_lo);
            lo_in = ch_lo;
            quo_in = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - div_ff;
            end
            quo_in = {quo_ff[HGC_CHAN_BITS-2:0], ge};
            div_in = div_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(HGC_CHAN_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            color_in[{ch_ff, 3'b000} +: HGC_CHAN_BITS] = chan;
            if (ch_ff == 2'd2) begin
               state_in = ST_PUSH;
            end else begin
               ch_in = ch_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_PUSH: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_color_in = color_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ch_ff <= ch_in;
      num_ff <= num_in;
      span_ff <= span_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      lo_ff <= lo_in;
      color_ff <= color_in;
      out_color_ff <= out_color_in;
   end

endmodule

// ===== rtl/core/height_gradient_colorizer.sv =====
// Maps signed height samples to 24-bit RGB colors on a linear gradient between the
// color_low and color_high registers. A scan transfer (operation 0) folds its height
// into the running minimum and maximum and produces no result; a color transfer
// (operation 1) produces one color, computed per channel exactly as
// low + floor((high - low) * (h - min) / (max - min)) with h clamped into the range,
// and equal to color_low when the range is flat. Scan transfers are taken at one per
// cycle while the two-entry queue has room; a full queue stalls every transfer. A
// color transfer is queued and then handled by the back end in order: a dequeue,
// then for each of the three channels a multiply, eight steps of the shared restoring
// divider and a final adjust, and last a load of the output register, which waits while
// a held response is not taken. The back end dequeues a new color item only after the
// last one is loaded into the output register.
module height_gradient_colorizer
   import hgc_pkg::*;
#(
   parameter int HEIGHT_BITS = HGC_HEIGHT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [HEIGHT_BITS-1:0] height, upper bits zero
   input  logic [((HEIGHT_BITS+7)/8)*8-1:0] req_tdata,
   // [0] operation, [1] scan_start
   input  logic [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [23:0] color
   output logic [HGC_COLOR_BITS-1:0]    rsp_tdata,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [HGC_CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [HGC_CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [HGC_CSR_DATA_BITS-1:0] csr_prdata,
   output logic                         csr_pready
);

   logic [HGC_COLOR_BITS-1:0] color_low_ff, color_low_in;
   logic [HGC_COLOR_BITS-1:0] color_high_ff, color_high_in;
   logic                      csr_write;

   hgc_q_stat_type            q_stat;
   logic                      q_push, q_pop;
   logic [2*HEIGHT_BITS-1:0]  q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      color_low_in = color_low_ff;
      color_high_in = color_high_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            HGC_REG_COLOR_LOW: color_low_in = csr_pwdata[HGC_COLOR_BITS-1:0];
            HGC_REG_COLOR_HIGH: color_high_in = csr_pwdata[HGC_COLOR_BITS-1:0];
            default: ;
         endcase
      end
      unique case (csr_paddr[2])
         HGC_REG_COLOR_LOW: csr_prdata = HGC_CSR_DATA_BITS'(color_low_ff);
         HGC_REG_COLOR_HIGH: csr_prdata = HGC_CSR_DATA_BITS'(color_high_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_low_ff <= HGC_COLOR_LOW_RESET;
         color_high_ff <= HGC_COLOR_HIGH_RESET;
      end else begin
         color_low_ff <= color_low_in;
         color_high_ff <= color_high_in;
      end
   end

   hgc_front #(
      .HEIGHT_BITS(HEIGHT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item_op    (req_tuser[0]),
      .item_start (req_tuser[1]),
      .item_height(req_tdata[HEIGHT_BITS-1:0]),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   hgc_fifo #(
      .WIDTH(2 * HEIGHT_BITS),
      .DEPTH(HGC_QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .stat     (q_stat)
   );

   hgc_back #(
      .HEIGHT_BITS(HEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .color_low (color_low_ff),
      .color_high(color_high_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_color (rsp_tdata)
   );

endmodule

// ===== verif/height_gradient_colorizer_tb.sv =====
module height_gradient_colorizer_tb;
   import hgc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PIPE_SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic [HGC_CSR_ADDR_BITS-1:0] COLOR_LOW_ADDR = {HGC_REG_COLOR_LOW, 2'b00};
   localparam logic [HGC_CSR_ADDR_BITS-1:0] COLOR_HIGH_ADDR = {HGC_REG_COLOR_HIGH, 2'b00};

   typedef struct {
      logic                              op;
      logic signed [HGC_HEIGHT_BITS-1:0] height;
      logic                              start;
   } height_item_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [HGC_HEIGHT_BITS-1:0]   req_tdata;
   logic [1:0]                   req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [HGC_COLOR_BITS-1:0]    rsp_tdata;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [HGC_CSR_ADDR_BITS-1:0] csr_paddr;
   logic [HGC_CSR_DATA_BITS-1:0] csr_pwdata;
   logic [HGC_CSR_DATA_BITS-1:0] csr_prdata;
   logic                         csr_pready;

   height_item_type             pending_items[$];
   logic [HGC_COLOR_BITS-1:0]   expected_colors[$];
   height_item_type             offered_item;

   logic signed [HGC_HEIGHT_BITS-1:0] range_min;
   logic signed [HGC_HEIGHT_BITS-1:0] range_max;
   logic                              range_seen;
   logic [HGC_COLOR_BITS-1:0]         low_color;
   logic [HGC_COLOR_BITS-1:0]         high_color;

   int   feed_idle_pct;
   int   drain_idle_pct;
   logic long_hold_arm;
   logic long_hold_done;
   int   hold_left;
   int   quiet_cycles;
   int   error_count;

   height_gradient_colorizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] mix_channel(logic [7:0] lo, logic [7:0] hi, int num, int span);
      int prod;
      int quot;
      if (span <= 0) begin
         return lo;
      end
      prod = (int'(hi) - int'(lo)) * num;
      if (prod >= 0) begin
         quot = prod / span;
      end else begin
         quot = -((-prod + span - 1) / span);
      end
      return 8'(int'(lo) + quot);
   endfunction

   task automatic fold_height_item(height_item_type it);
      int h;
      int num;
      int span;
      if (it.op == HGC_OP_SCAN) begin
         if (it.start || !range_seen) begin
            range_min = it.height;
            range_max = it.height;
            range_seen = 1'b1;
         end else begin
            if (it.height > range_max) begin
               range_max = it.height;
            end
            if (it.height < range_min) begin
               range_min = it.height;
            end
         end
      end else begin
         h = int'(it.height);
         if (h < int'(range_min)) begin
            h = int'(range_min);
         end
         if (h > int'(range_max)) begin
            h = int'(range_max);
         end
         num = h - int'(range_min);
         span = int'(range_max) - int'(range_min);
         expected_colors.push_back({mix_channel(low_color[23:16], high_color[23:16], num, span),
                                    mix_channel(low_color[15:8], high_color[15:8], num, span),
                                    mix_channel(low_color[7:0], high_color[7:0], num, span)});
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("color check failed at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic push_item(logic op, logic [HGC_HEIGHT_BITS-1:0] h, logic start);
      height_item_type it;
      it.op = op;
      it.height = h;
      it.start = start;
      pending_items.push_back(it);
   endtask

   task automatic write_csr(logic [HGC_CSR_ADDR_BITS-1:0] addr, logic [HGC_COLOR_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {8'h00, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == COLOR_LOW_ADDR) begin
         low_color = value;
      end else begin
         high_color = value;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_tvalid || expected_colors.size() != 0);
      repeat (PIPE_SETTLE_CYCLES) @(negedge clock);
   endtask

   // Runs are a scan that usually restarts the range, a few more scans around the same center, then
   // colors reaching slightly past the scanned range. About one run in ten is a single noise item.
   task automatic queue_random_runs(int count);
      int made;
      int k;
      int spread;
      int wide;
      int center;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            push_item(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
            made++;
         end else begin
            case ($urandom_range(3))
               0: spread = 0;
               1: spread = $urandom_range(1, 15);
               2: spread = $urandom_range(16, 4000);
               default: spread = 65535;
            endcase
            wide = spread + spread / 2 + 2;
            center = int'($urandom_range(0, 65535));
            push_item(HGC_OP_SCAN, 16'(center), 1'($urandom_range(4) != 0));
            k = $urandom_range(0, 4);
            repeat (k) begin
               push_item(HGC_OP_SCAN, 16'(center + int'($urandom_range(0, spread)) - spread / 2),
                         1'($urandom_range(15) == 0));
            end
            made += k + 1;
            k = $urandom_range(1, 6);
            repeat (k) begin
               push_item(HGC_OP_COLOR, 16'(center + int'($urandom_range(0, wide)) - wide / 2),
                         1'($urandom_range(1)));
            end
            made += k;
         end
      end
   endtask

   always @(posedge clock) begin : feed_items
      height_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            fold_height_item(offered_item);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
               nxt = pending_items.pop_front();
               offered_item <= nxt;
               req_tvalid <= 1'b1;
               req_tdata <= nxt.height;
               req_tuser <= {nxt.start, nxt.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (long_hold_arm && !long_hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= drain_idle_pct);
      end
   end

   always @(posedge clock) begin : check_colors
      logic [HGC_COLOR_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_colors.size() == 0) begin
            report_mismatch($sformatf("unexpected color %06h", rsp_tdata));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch($sformatf("color %06h, expected %06h", rsp_tdata, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("height_gradient_colorizer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      feed_idle_pct = 0;
      drain_idle_pct = 0;
      long_hold_arm = 1'b0;
      quiet_cycles = 0;
      error_count = 0;
      range_min = '0;
      range_max = '0;
      range_seen = 1'b0;
      low_color = HGC_COLOR_LOW_RESET;
      high_color = HGC_COLOR_HIGH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Colors before any scan, first scan without a restart, flat and clamped ranges.
      push_item(HGC_OP_COLOR, 16'h0000, 1'b0);
      push_item(HGC_OP_COLOR, 16'h7fff, 1'b1);
      push_item(HGC_OP_SCAN, 16'd100, 1'b0);
      push_item(HGC_OP_COLOR, 16'd100, 1'b0);
      push_item(HGC_OP_COLOR, 16'h8000, 1'b0);
      push_item(HGC_OP_SCAN, 16'h8000, 1'b0);
      push_item(HGC_OP_SCAN, 16'h7fff, 1'b0);
      push_item(HGC_OP_COLOR, 16'h8000, 1'b0);
      push_item(HGC_OP_COLOR, 16'h7fff, 1'b0);
      push_item(HGC_OP_COLOR, 16'h0000, 1'b1);
      push_item(HGC_OP_COLOR, 16'hffff, 1'b0);
      push_item(HGC_OP_SCAN, 16'd5, 1'b1);
      push_item(HGC_OP_SCAN, 16'd5, 1'b0);
      push_item(HGC_OP_COLOR, 16'd5, 1'b0);
      push_item(HGC_OP_COLOR, 16'h8000, 1'b0);
      push_item(HGC_OP_COLOR, 16'h7fff, 1'b0);
      push_item(HGC_OP_SCAN, 16'hffec, 1'b0);
      push_item(HGC_OP_COLOR, 16'h0000, 1'b0);
      push_item(HGC_OP_COLOR, 16'hffec, 1'b0);
      push_item(HGC_OP_COLOR, 16'd4, 1'b0);
      push_item(HGC_OP_COLOR, 16'hfff9, 1'b1);
      wait_drained();

      write_csr(COLOR_LOW_ADDR, 24'hffffff);
      write_csr(COLOR_HIGH_ADDR, 24'h000000);
      feed_idle_pct = 7;
      drain_idle_pct = 82;
      queue_random_runs(330);
      wait_drained();

      write_csr(COLOR_LOW_ADDR, 24'($urandom));
      write_csr(COLOR_HIGH_ADDR, 24'($urandom));
      feed_idle_pct = 82;
      drain_idle_pct = 7;
      queue_random_runs(330);
      wait_drained();

      write_csr(COLOR_LOW_ADDR, 24'h5a3c96);
      write_csr(COLOR_HIGH_ADDR, 24'h5a3c96);
      feed_idle_pct = 0;
      drain_idle_pct = 0;
      queue_random_runs(40);
      wait_drained();

      write_csr(COLOR_LOW_ADDR, 24'($urandom));
      write_csr(COLOR_HIGH_ADDR, 24'($urandom));
      long_hold_arm = 1'b1;
      queue_random_runs(330);
      wait_drained();

      if (error_count == 0) begin
         $display("height_gradient_colorizer: match");
      end else begin
         $display("height_gradient_colorizer: mismatch");
      end
      $finish;
   end

endmodule
